// File: hdl/analog_key_rapid_trigger_assert.svh
// Assertion macros shared by the analog key qualifier RTL.
`ifndef ANALOG_KEY_RAPID_TRIGGER_ASSERT_SVH
`define ANALOG_KEY_RAPID_TRIGGER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define AKRT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define AKRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AKRT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define AKRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/akrt_pkg.sv
// Shared types, codes and helpers of the analog key qualifier.
package akrt_pkg;

  localparam int KEY_W      = 7;
  localparam int TRAVEL_W   = 10;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int KEY_COUNT_DEF  = 128;
  localparam int TRAVEL_MAX_DEF = 1023;
  localparam int QDEPTH         = 2;

  localparam int RST_ACT = 400;
  localparam int RST_REL = 350;
  localparam int RST_OFF = 50;

  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FOLLOW  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ACT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REL_OFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RT        = 3'd4;

  typedef enum logic [2:0] {
    OP_SAMPLE,
    OP_SET,
    OP_FOLLOW,
    OP_RELEASE,
    OP_IGNORE
  } akrt_op_t;

  typedef struct packed {
    logic [TRAVEL_W-1:0] act;
    logic [TRAVEL_W-1:0] rel;
    logic [TRAVEL_W-1:0] act_off;
    logic [TRAVEL_W-1:0] rel_off;
    logic                rt;
  } key_cfg_t;

  typedef struct packed {
    akrt_op_t            op;
    logic [KEY_W-1:0]    key;
    logic [TRAVEL_W-1:0] travel;
    key_cfg_t            cfg;
  } item_t;

  typedef enum logic {
    BK_READ,
    BK_EXEC
  } bk_state_t;

  // Saturate a travel-sized value to the travel ceiling.
  function automatic logic [TRAVEL_W-1:0] sat_travel(input logic [TRAVEL_W-1:0] v,
                                                     input int unsigned max_val);
    logic [16:0] wide;
    wide = {7'b0, v};
    if (wide > 17'(max_val)) begin
      return TRAVEL_W'(max_val);
    end
    return v;
  endfunction

endpackage

// File: hdl/akrt_front.sv
// Front end: takes input beats, classifies the mode and clamps custom settings.
module akrt_front import akrt_pkg::*; #(
  parameter int KEY_COUNT  = KEY_COUNT_DEF,
  parameter int TRAVEL_MAX = TRAVEL_MAX_DEF
) (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [KEY_W-1:0]    key,
  input  logic [TRAVEL_W-1:0] travel,
  input  logic [TRAVEL_W-1:0] act_thr,
  input  logic [TRAVEL_W-1:0] rel_thr,
  input  logic [TRAVEL_W-1:0] act_off,
  input  logic [TRAVEL_W-1:0] rel_off,
  input  logic                rt_enable,
  input  logic                q_full,
  output logic                push,
  output item_t               push_item
);

  logic in_range;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign in_range = {2'b0, key} < 9'(KEY_COUNT);

  always_comb begin
    push_item.key         = key;
    push_item.travel      = travel;
    push_item.cfg.act     = sat_travel(act_thr, TRAVEL_MAX);
    push_item.cfg.rel     = sat_travel(rel_thr, TRAVEL_MAX);
    push_item.cfg.act_off = sat_travel(act_off, TRAVEL_MAX);
    push_item.cfg.rel_off = sat_travel(rel_off, TRAVEL_MAX);
    push_item.cfg.rt      = rt_enable;
    push_item.op          = OP_IGNORE;
    if (in_range) begin
      unique case (mode)
        MODE_SAMPLE:  push_item.op = OP_SAMPLE;
        MODE_SET:     push_item.op = OP_SET;
        MODE_FOLLOW:  push_item.op = OP_FOLLOW;
        MODE_RELEASE: push_item.op = OP_RELEASE;
        default:      push_item.op = OP_IGNORE;
      endcase
    end
  end

endmodule

// File: hdl/akrt_queue.sv
// Short queue between front and back end.
`include "analog_key_rapid_trigger_assert.svh"
module akrt_queue import akrt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output item_t head
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t              entries [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `AKRT_ASSERT_IMPL(a_no_pop_empty, clk, rst, count == '0, !pop, "pop from empty queue")
  `AKRT_ASSERT_IMPL(a_no_push_full, clk, rst, full, !push, "push into full queue")
  `AKRT_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, count != '0, "push lost")

endmodule

// File: hdl/akrt_back.sv
// Back end: per-key read-modify-write of settings and switch state, result register.
`include "analog_key_rapid_trigger_assert.svh"
module akrt_back import akrt_pkg::*; #(
  parameter int KEY_COUNT  = KEY_COUNT_DEF,
  parameter int TRAVEL_MAX = TRAVEL_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  key_cfg_t         glb,
  input  logic             q_nonempty,
  input  item_t            q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] out_key,
  output logic             changed,
  output logic             pressed
);

  localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam logic [TRAVEL_W-1:0] EXT_RESET = sat_travel(TRAVEL_W'(RST_ACT), TRAVEL_MAX);

  typedef struct packed {
    logic                pressed;
    logic [TRAVEL_W-1:0] ext;
  } key_state_t;

  key_cfg_t   cfg_mem [KEY_COUNT];
  key_state_t st_mem  [KEY_COUNT];
  logic       custom  [KEY_COUNT];
  logic       stv     [KEY_COUNT];

  bk_state_t  state;
  bk_state_t  state_next;
  item_t      cur;
  key_cfg_t   cfg_rd;
  key_state_t st_rd;

  logic [IDX_W-1:0] hidx;
  logic [IDX_W-1:0] cidx;
  logic [7:0]       hkey8;
  logic [7:0]       ckey8;
  logic             commit;
  logic             rd_en;
  logic             st_we;
  logic             cfg_we;

  key_cfg_t            eff;
  logic                cur_p;
  logic [TRAVEL_W-1:0] cur_e;
  logic [TRAVEL_W-1:0] lo;
  logic [TRAVEL_W-1:0] hi;
  logic [TRAVEL_W:0]   sw_plus;
  logic [TRAVEL_W:0]   e_plus;
  logic                p_new;
  logic [TRAVEL_W-1:0] e_new;
  logic                chg;

  assign hkey8 = {1'b0, q_head.key};
  assign ckey8 = {1'b0, cur.key};
  assign hidx  = hkey8[IDX_W-1:0];
  assign cidx  = ckey8[IDX_W-1:0];

  // Sequencer: read cycle, then execute cycle held until the result slot frees.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_READ: if (q_nonempty) state_next = BK_EXEC;
      BK_EXEC: if (commit) state_next = BK_READ;
      default: state_next = BK_READ;
    endcase
  end

  always_comb begin
    pop    = (state == BK_READ) && q_nonempty;
    commit = (state == BK_EXEC) && (!out_valid || !out_stall);
    rd_en  = pop && (q_head.op != OP_IGNORE);
    st_we  = commit && (cur.op == OP_SAMPLE || cur.op == OP_RELEASE);
    cfg_we = commit && (cur.op == OP_SET);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_READ;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  // Tables: one read port, one write port, registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cfg_rd <= cfg_mem[hidx];
      st_rd  <= st_mem[hidx];
    end
    if (cfg_we) begin
      cfg_mem[cidx] <= cur.cfg;
    end
    if (st_we) begin
      st_mem[cidx] <= '{pressed: p_new, ext: e_new};
    end
  end

  // Per-key flags: custom settings in use, and switch state written at least once.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        custom[i] <= 1'b0;
        stv[i]    <= 1'b0;
      end
    end else begin
      if (commit && cur.op == OP_SET) begin
        custom[cidx] <= 1'b1;
      end else if (commit && cur.op == OP_FOLLOW) begin
        custom[cidx] <= 1'b0;
      end
      if (st_we) begin
        stv[cidx] <= 1'b1;
      end
    end
  end

  // Dead zones first, then rapid trigger inside the band.
  always_comb begin
    eff     = custom[cidx] ? cfg_rd : glb;
    cur_p   = stv[cidx] ? st_rd.pressed : 1'b0;
    cur_e   = stv[cidx] ? st_rd.ext : EXT_RESET;
    lo      = (eff.rel > eff.act) ? eff.act : eff.rel;
    hi      = (eff.rel > eff.act) ? eff.rel : eff.act;
    sw_plus = {1'b0, cur.travel} + {1'b0, eff.rel_off};
    e_plus  = {1'b0, cur_e} + {1'b0, eff.act_off};
    p_new   = cur_p;
    e_new   = cur_e;
    chg     = 1'b0;
    unique case (cur.op)
      OP_SAMPLE: begin
        if (cur.travel < lo) begin
          if (cur_p) begin
            e_new = cur.travel;
            p_new = 1'b0;
            chg   = 1'b1;
          end else if (cur.travel < cur_e) begin
            e_new = cur.travel;
          end
        end else if (cur.travel > hi) begin
          if (!cur_p) begin
            e_new = cur.travel;
            p_new = 1'b1;
            chg   = 1'b1;
          end else if (cur.travel > cur_e) begin
            e_new = cur.travel;
          end
        end else if (eff.rt) begin
          if (cur_p) begin
            if (eff.rel_off != '0) begin
              if (cur.travel > cur_e) begin
                e_new = cur.travel;
              end else if (sw_plus < {1'b0, cur_e}) begin
                e_new = cur.travel;
                p_new = 1'b0;
                chg   = 1'b1;
              end
            end
          end else begin
            if (eff.act_off != '0) begin
              if (cur.travel < cur_e) begin
                e_new = cur.travel;
              end else if ({1'b0, cur.travel} > e_plus) begin
                e_new = cur.travel;
                p_new = 1'b1;
                chg   = 1'b1;
              end
            end
          end
        end
      end
      OP_RELEASE: begin
        chg   = cur_p;
        p_new = 1'b0;
      end
      OP_SET, OP_FOLLOW: begin
        chg = 1'b0;
      end
      default: begin
        p_new = 1'b0;
        chg   = 1'b0;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_key <= cur.key;
      changed <= chg;
      pressed <= p_new;
    end
  end

  `AKRT_ASSERT_NEXT(a_pop_exec, clk, rst, pop, state == BK_EXEC, "pop did not start execute")
  `AKRT_ASSERT_NEXT(a_hold_exec, clk, rst, state == BK_EXEC && !commit,
                    state == BK_EXEC && $stable(cur), "blocked item not held")
  `AKRT_ASSERT_NEXT(a_ignore_quiet, clk, rst, commit && cur.op == OP_IGNORE,
                    !changed && !pressed, "out-of-range key reported a state")
  `AKRT_ASSERT_NEXT(a_release_low, clk, rst, commit && cur.op == OP_RELEASE,
                    out_valid && !pressed, "forced release left key pressed")

endmodule

// File: hdl/analog_key_rapid_trigger.sv
// Top level of the analog key qualifier with hysteresis and rapid trigger.
//
//  channel   signals                                       direction  handshake
//  -------   --------------------------------------------  ---------  -------------------
//  in        mode key travel act_thr rel_thr act_off        sink       in_valid / in_stall
//            rel_off rt_enable
//  out       out_key changed pressed                       source     out_valid / out_stall
//  cfg       cfg_index cfg_data                            sink       cfg_we, no wait
//
//  Steps: the back end reads the key's settings and switch-state tables in its read
//  state, then evaluates and writes them back in its execute state, and takes no new
//  beat from the queue until that write-back commits. A result beat passes through the
//  queue, the read state and the execute state into the output register.
//  Reset: synchronous; per-key flag flops restore the reset settings and state at once,
//  so there is no clearing pass and a beat is taken the cycle after reset drops.
//  Stalls: a two-beat queue sits between front and back, so the front keeps taking
//  beats while a result waits in the output register, until the queue fills; the back
//  holds its item in the execute cycle until the output register frees.
module analog_key_rapid_trigger import akrt_pkg::*; #(
  parameter int KEY_COUNT  = KEY_COUNT_DEF,
  parameter int TRAVEL_MAX = TRAVEL_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     mode,
  input  logic [KEY_W-1:0]      key,
  input  logic [TRAVEL_W-1:0]   travel,
  input  logic [TRAVEL_W-1:0]   act_thr,
  input  logic [TRAVEL_W-1:0]   rel_thr,
  input  logic [TRAVEL_W-1:0]   act_off,
  input  logic [TRAVEL_W-1:0]   rel_off,
  input  logic                  rt_enable,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KEY_W-1:0]      out_key,
  output logic                  changed,
  output logic                  pressed
);

  key_cfg_t glb;
  logic     q_full;
  logic     q_nonempty;
  logic     push;
  logic     pop;
  item_t    push_item;
  item_t    q_head;

  // Global settings registers; values clamp to the travel ceiling on write,
  // and an index past the list drops the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      glb.act     <= sat_travel(TRAVEL_W'(RST_ACT), TRAVEL_MAX);
      glb.rel     <= sat_travel(TRAVEL_W'(RST_REL), TRAVEL_MAX);
      glb.act_off <= sat_travel(TRAVEL_W'(RST_OFF), TRAVEL_MAX);
      glb.rel_off <= sat_travel(TRAVEL_W'(RST_OFF), TRAVEL_MAX);
      glb.rt      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACT:       glb.act     <= sat_travel(cfg_data, TRAVEL_MAX);
        REG_REL:       glb.rel     <= sat_travel(cfg_data, TRAVEL_MAX);
        REG_PRESS_OFF: glb.act_off <= sat_travel(cfg_data, TRAVEL_MAX);
        REG_REL_OFF:   glb.rel_off <= sat_travel(cfg_data, TRAVEL_MAX);
        REG_RT:        glb.rt      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify and clamp, then hand over to the queue.
  akrt_front #(
    .KEY_COUNT  (KEY_COUNT),
    .TRAVEL_MAX (TRAVEL_MAX)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .key       (key),
    .travel    (travel),
    .act_thr   (act_thr),
    .rel_thr   (rel_thr),
    .act_off   (act_off),
    .rel_off   (rel_off),
    .rt_enable (rt_enable),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  akrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // Per-key read-modify-write and the result register.
  akrt_back #(
    .KEY_COUNT  (KEY_COUNT),
    .TRAVEL_MAX (TRAVEL_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .glb        (glb),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_key    (out_key),
    .changed    (changed),
    .pressed    (pressed)
  );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the analog key qualifier: directed, backpressure and random beats.
module tb_top;
  import akrt_pkg::*;

  // One predicted result beat.
  typedef struct {
    logic [KEY_W-1:0] key;
    logic             chg;
    logic             prs;
  } key_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [MODE_W-1:0]     mode = '0;
  logic [KEY_W-1:0]      key = '0;
  logic [TRAVEL_W-1:0]   travel = '0;
  logic [TRAVEL_W-1:0]   act_thr = '0;
  logic [TRAVEL_W-1:0]   rel_thr = '0;
  logic [TRAVEL_W-1:0]   act_off = '0;
  logic [TRAVEL_W-1:0]   rel_off = '0;
  logic                  rt_enable = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [KEY_W-1:0]      out_key;
  logic                  changed;
  logic                  pressed;

  analog_key_rapid_trigger DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .key(key), .travel(travel),
    .act_thr(act_thr), .rel_thr(rel_thr), .act_off(act_off), .rel_off(rel_off),
    .rt_enable(rt_enable),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_key(out_key), .changed(changed), .pressed(pressed)
  );

  // Shadow of the block: global registers, per-key settings and switch state.
  key_cfg_t            glb;
  key_cfg_t            own_cfg   [KEY_COUNT_DEF];
  logic                follow_glb[KEY_COUNT_DEF];
  logic [TRAVEL_W-1:0] peak      [KEY_COUNT_DEF];
  logic                key_down  [KEY_COUNT_DEF];

  key_report_t pending_reports[$];

  int beats_sent   = 0;
  int reports_seen = 0;
  int err_count    = 0;

  // Idling control shared by the sender task and the receiver process.
  bit idle_on  = 1'b1;
  int tx_calm  = 0;
  int rx_burst = 0;
  int rx_calm  = 0;
  int hold_len = 0;

  // Last travel offered per key, so random samples walk instead of jumping.
  int last_trav[KEY_COUNT_DEF];

  initial begin
    forever #10 clk = ~clk;
  end

  // Give up well past the slowest legal run.
  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic key_cfg_t pack_cfg(input int a, input int r, input int ao, input int ro,
                                        input bit rt);
    key_cfg_t c;
    c.act     = TRAVEL_W'(a);
    c.rel     = TRAVEL_W'(r);
    c.act_off = TRAVEL_W'(ao);
    c.rel_off = TRAVEL_W'(ro);
    c.rt      = rt;
    return c;
  endfunction

  function automatic void log_mismatch(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  // Restore the shadow to its post-reset contents.
  function automatic void reset_shadow();
    glb = pack_cfg(RST_ACT, RST_REL, RST_OFF, RST_OFF, 1'b0);
    for (int i = 0; i < KEY_COUNT_DEF; i++) begin
      own_cfg[i]    = glb;
      follow_glb[i] = 1'b1;
      peak[i]       = TRAVEL_W'(RST_ACT);
      key_down[i]   = 1'b0;
      last_trav[i]  = RST_ACT;
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ACT:       glb.act     = data;
      REG_REL:       glb.rel     = data;
      REG_PRESS_OFF: glb.act_off = data;
      REG_REL_OFF:   glb.rel_off = data;
      REG_RT:        glb.rt      = data[0];
      default: ;
    endcase
  endfunction

  // Work out the result of one accepted beat and advance the shadow.
  function automatic void qualify_beat(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                                       input logic [TRAVEL_W-1:0] trv, input key_cfg_t custom);
    key_cfg_t            eff;
    logic [TRAVEL_W-1:0] hi;
    logic [TRAVEL_W-1:0] lo;
    logic                chg;
    int                  s;
    int                  e;
    key_report_t         rep;
    chg = 1'b0;
    case (m)
      MODE_SAMPLE: begin
        eff = follow_glb[k] ? glb : own_cfg[k];
        hi  = eff.act;
        lo  = eff.rel;
        // Compare against the ordered pair when the thresholds are inverted.
        if (lo > hi) begin
          hi = eff.rel;
          lo = eff.act;
        end
        s = int'(trv);
        e = int'(peak[k]);
        if (trv < lo) begin
          // Upper dead zone: release, or track the valley.
          if (key_down[k]) begin
            peak[k]     = trv;
            key_down[k] = 1'b0;
            chg         = 1'b1;
          end else if (trv < peak[k]) begin
            peak[k] = trv;
          end
        end else if (trv > hi) begin
          // Lower dead zone: press, or track the peak.
          if (!key_down[k]) begin
            peak[k]     = trv;
            key_down[k] = 1'b1;
            chg         = 1'b1;
          end else if (trv > peak[k]) begin
            peak[k] = trv;
          end
        end else if (eff.rt) begin
          if (key_down[k]) begin
            if (eff.rel_off != '0) begin
              if (s > e) begin
                peak[k] = trv;
              end else if (s < e - int'(eff.rel_off)) begin
                peak[k]     = trv;
                key_down[k] = 1'b0;
                chg         = 1'b1;
              end
            end
          end else if (eff.act_off != '0) begin
            if (s < e) begin
              peak[k] = trv;
            end else if (s > e + int'(eff.act_off)) begin
              peak[k]     = trv;
              key_down[k] = 1'b1;
              chg         = 1'b1;
            end
          end
        end
      end
      MODE_SET: begin
        own_cfg[k]    = custom;
        follow_glb[k] = 1'b0;
      end
      MODE_FOLLOW: begin
        own_cfg[k]    = glb;
        follow_glb[k] = 1'b1;
      end
      MODE_RELEASE: begin
        chg         = key_down[k];
        key_down[k] = 1'b0;
      end
      default: ;
    endcase
    rep.key = k;
    rep.chg = chg;
    rep.prs = key_down[k];
    pending_reports.push_back(rep);
  endfunction

  // Watch both channels and the register port on every edge. Check the result
  // beat first; it always belongs to an older input beat.
  always @(posedge clk) begin : monitor
    key_report_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          log_mismatch($sformatf("unexpected result: key %0d changed %0b pressed %0b",
                                 out_key, changed, pressed));
        end else begin
          want = pending_reports.pop_front();
          if (out_key !== want.key || changed !== want.chg || pressed !== want.prs) begin
            log_mismatch($sformatf(
              "mismatch: key exp %0d got %0d, changed exp %0b got %0b, pressed exp %0b got %0b",
              want.key, out_key, want.chg, changed, want.prs, pressed));
          end
        end
      end
      if (in_valid && !in_stall) begin
        qualify_beat(mode, key, travel,
                     pack_cfg(act_thr, rel_thr, act_off, rel_off, rt_enable));
      end
      if (cfg_we) apply_reg(cfg_index, cfg_data);
    end
  end

  // Receiver: a long hold when asked; with idling off no stall, else random stall bursts and calm stretches.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        hold_len--;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
      end else if (rx_burst > 0) begin
        out_stall <= 1'b1;
        rx_burst--;
      end else if (rx_calm > 0) begin
        out_stall <= 1'b0;
        rx_calm--;
      end else if ($urandom_range(0, 40) == 0) begin
        out_stall <= 1'b0;
        rx_calm = $urandom_range(20, 80);
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        rx_burst = $urandom_range(0, 16);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one beat and return at the edge that takes it. Valid stays high so
  // the next beat can follow back to back.
  task automatic offer_beat(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                            input logic [TRAVEL_W-1:0] trv, input key_cfg_t c);
    if (idle_on) begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else if ($urandom_range(0, 30) == 0) begin
        tx_calm = $urandom_range(10, 40);
      end else if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    mode      <= m;
    key       <= k;
    travel    <= trv;
    act_thr   <= c.act;
    rel_thr   <= c.rel;
    act_off   <= c.act_off;
    rel_off   <= c.rel_off;
    rt_enable <= c.rt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid and hold until every beat offered so far has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (reports_seen < beats_sent) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write all global registers, then a random index past the last register.
  task automatic load_globals(input int a, input int r, input int po, input int ro,
                              input bit rt);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACT;
    cfg_data  <= CFG_DATA_W'(a);
    @(posedge clk);
    cfg_index <= REG_REL;
    cfg_data  <= CFG_DATA_W'(r);
    @(posedge clk);
    cfg_index <= REG_PRESS_OFF;
    cfg_data  <= CFG_DATA_W'(po);
    @(posedge clk);
    cfg_index <= REG_REL_OFF;
    cfg_data  <= CFG_DATA_W'(ro);
    @(posedge clk);
    // Upper data bits are don't-care for the one-bit enable; toggle them anyway.
    cfg_index <= REG_RT;
    cfg_data  <= CFG_DATA_W'({$urandom, rt});
    @(posedge clk);
    cfg_index <= REG_RT + CFG_IDX_W'($urandom_range(1, 3));
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reset settings: hysteresis only, plus force release on idle and held keys.
  task automatic test_default_hysteresis();
    offer_beat(MODE_SAMPLE, 7'd0, 10'd375, '0);
    offer_beat(MODE_SAMPLE, 7'd0, 10'd0, '0);
    offer_beat(MODE_SAMPLE, 7'd0, 10'd1023, '0);
    offer_beat(MODE_SAMPLE, 7'd0, 10'd1023, '0);
    offer_beat(MODE_SAMPLE, 7'd0, 10'd500, '0);
    offer_beat(MODE_SAMPLE, 7'd0, 10'd349, '0);
    offer_beat(MODE_RELEASE, 7'd0, 10'd0, '0);
    offer_beat(MODE_SAMPLE, 7'd127, 10'd401, '0);
    offer_beat(MODE_RELEASE, 7'd127, 10'd0, '0);
    settle();
  endtask

  // Custom settings with inverted thresholds and a zero release offset, then back to global.
  task automatic test_custom_settings();
    offer_beat(MODE_SET, 7'd5, 10'd0, pack_cfg(300, 600, 1023, 0, 1'b1));
    offer_beat(MODE_SAMPLE, 7'd5, 10'd700, '0);
    offer_beat(MODE_SAMPLE, 7'd5, 10'd650, '0);
    offer_beat(MODE_SAMPLE, 7'd5, 10'd400, '0);
    offer_beat(MODE_SAMPLE, 7'd5, 10'd100, '0);
    offer_beat(MODE_SET, 7'd127, 10'd1023, pack_cfg(1023, 0, 1023, 1023, 1'b0));
    offer_beat(MODE_FOLLOW, 7'd5, 10'd0, '0);
    settle();
  endtask

  // Rapid trigger through the global registers: press, follow, release, follow, press.
  task automatic test_rapid_trigger();
    load_globals(900, 100, 40, 40, 1'b1);
    offer_beat(MODE_SAMPLE, 7'd9, 10'd500, '0);
    offer_beat(MODE_SAMPLE, 7'd9, 10'd600, '0);
    offer_beat(MODE_SAMPLE, 7'd9, 10'd550, '0);
    offer_beat(MODE_SAMPLE, 7'd9, 10'd540, '0);
    offer_beat(MODE_SAMPLE, 7'd9, 10'd520, '0);
    offer_beat(MODE_SAMPLE, 7'd9, 10'd561, '0);
    settle();
  endtask

  // Hold the result side off for a long stretch while beats keep coming, so the
  // queue fills and the block stalls its input.
  task automatic test_backpressure();
    tx_calm  = 30;
    hold_len = 150;
    for (int i = 0; i < 24; i++) begin
      offer_beat(MODE_SAMPLE, KEY_W'($urandom_range(0, 3)), TRAVEL_W'($urandom), '0);
    end
    settle();
  endtask

  function automatic int pick_offset();
    int r;
    r = $urandom_range(0, 4);
    if (r == 0) return 0;
    if (r == 4) return $urandom_range(0, 1023);
    return $urandom_range(1, 80);
  endfunction

  // Mostly sample walks on a few hot keys, mixed with setting changes and releases.
  task automatic random_burst(input int count);
    logic [KEY_W-1:0]  hot[6];
    logic [KEY_W-1:0]  k;
    logic [MODE_W-1:0] m;
    key_cfg_t          c;
    int                t;
    int                r;
    foreach (hot[i]) hot[i] = KEY_W'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) k = hot[$urandom_range(0, 5)];
      else k = KEY_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 72) m = MODE_SAMPLE;
      else if (r < 84) m = MODE_SET;
      else if (r < 92) m = MODE_FOLLOW;
      else m = MODE_RELEASE;
      c = pack_cfg($urandom_range(0, 1023), $urandom_range(0, 1023), pick_offset(),
                   pick_offset(), $urandom_range(0, 3) != 0);
      if (m == MODE_SAMPLE && $urandom_range(0, 4) != 0) begin
        t = last_trav[k] + int'($urandom_range(0, 240)) - 120;
        if (t < 0) t = 0;
        if (t > 1023) t = 1023;
      end else begin
        t = $urandom_range(0, 1023);
      end
      if (m == MODE_SAMPLE) last_trav[k] = t;
      offer_beat(m, k, TRAVEL_W'(t), c);
    end
  endtask

  // Several global settings, the extremes among them; the last phase runs without idling.
  task automatic test_random_phases();
    load_globals(400, 350, 50, 50, 1'b1);
    random_burst(280);
    settle();
    load_globals(1023, 0, 1, 1023, 1'b1);
    random_burst(280);
    settle();
    load_globals(200, 700, 0, 30, 1'b1);
    random_burst(280);
    settle();
    load_globals(0, 0, 0, 0, 1'b0);
    random_burst(280);
    settle();
    load_globals($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(1, 100),
                 $urandom_range(1, 100), 1'b1);
    idle_on = 1'b0;
    random_burst(280);
    settle();
  endtask

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_hysteresis();
    test_custom_settings();
    test_rapid_trigger();
    test_backpressure();
    test_random_phases();
    repeat (10) @(posedge clk);
    if (pending_reports.size() != 0) begin
      log_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/akrt_pkg.sv
hdl/akrt_front.sv
hdl/akrt_queue.sv
hdl/akrt_back.sv
hdl/analog_key_rapid_trigger.sv
bench/tb_top.sv
